[src/dbc_pkg.sv]
// Shared constants, register codes and the divider cell record for the
// density bucket classifier. No dependencies.
package dbc_pkg;

  localparam int OPCODE_W   = 1;
  localparam int ENTRY_W    = 10;
  localparam int DENS_W     = 32;
  localparam int BIDX_W     = 10;
  localparam int POP_W      = 32;
  localparam int BCNT_W     = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Quotient bits of the uniform-mode division: the quotient stays below
  // the bucket count, which never exceeds BCNT_W bits.
  localparam int QUO_W  = BCNT_W;
  localparam int PROD_W = DENS_W + BCNT_W;

  localparam int DEF_MAX_BUCKETS = 1024;

  localparam logic [OPCODE_W-1:0] OP_CLASSIFY = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_WRITE    = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_QUANTILE_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUCKET_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DENSITY_LOW   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DENSITY_HIGH  = 2'd3;

  localparam logic [BCNT_W-1:0] RST_BUCKET_COUNT = 11'd1024;
  localparam logic [DENS_W-1:0] RST_DENSITY_LOW  = 32'h0000_0000;
  localparam logic [DENS_W-1:0] RST_DENSITY_HIGH = 32'hFFFF_FFFF;

  // What one division cell hands to the next.
  typedef struct packed {
    logic              vld;
    logic [DENS_W-1:0] rem;
    logic [QUO_W-1:0]  low;
    logic [QUO_W-1:0]  quo;
    logic [DENS_W-1:0] dvs;
  } div_cell_t;

endpackage

[src/dbc_if.sv]
// Valid/ready channel interfaces for requests and results.
// Depends on dbc_pkg for the payload widths.
interface dbc_in_if;
  import dbc_pkg::*;
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [ENTRY_W-1:0]  entry_index;
  logic [DENS_W-1:0]   density_value;

  modport source (output valid, output opcode, output entry_index,
                  output density_value, input ready);
  modport sink   (input valid, input opcode, input entry_index,
                  input density_value, output ready);
endinterface

interface dbc_out_if;
  import dbc_pkg::*;
  logic              valid;
  logic              ready;
  logic [BIDX_W-1:0] bucket_id;
  logic [POP_W-1:0]  bucket_population;

  modport source (output valid, output bucket_id, output bucket_population,
                  input ready);
  modport sink   (input valid, input bucket_id, input bucket_population,
                  output ready);
endinterface

[src/dbc_div_cell.sv]
// One restoring division cell: settles one quotient bit and passes the
// partial remainder on. Depends on dbc_pkg.
module dbc_div_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  dbc_pkg::div_cell_t c_in,
  output dbc_pkg::div_cell_t c_out
);
  import dbc_pkg::*;

  logic [DENS_W:0]   trial;
  logic              ge;
  logic [DENS_W:0]   diff;
  div_cell_t         c_nxt;
  div_cell_t         c_r;

  always_comb begin
    trial     = {c_in.rem, c_in.low[QUO_W-1]};
    ge        = trial >= {1'b0, c_in.dvs};
    diff      = trial - {1'b0, c_in.dvs};
    c_nxt.vld = c_in.vld;
    c_nxt.rem = ge ? diff[DENS_W-1:0] : trial[DENS_W-1:0];
    c_nxt.low = {c_in.low[QUO_W-2:0], 1'b0};
    c_nxt.quo = {c_in.quo[QUO_W-2:0], ge};
    c_nxt.dvs = c_in.dvs;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r.vld <= 1'b0;
    end else begin
      c_r <= c_nxt;
    end
  end

  assign c_out = c_r;

endmodule

[src/dbc_div_chain.sv]
// Uniform-mode bucket divider: a registered offset-by-count product feeding
// a row of dbc_div_cell, one quotient bit per cell. Depends on dbc_pkg.
module dbc_div_chain (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [dbc_pkg::DENS_W-1:0] offs,
  input  logic [dbc_pkg::BCNT_W-1:0] nbkt,
  input  logic [dbc_pkg::DENS_W-1:0] span,
  output logic                      done,
  output logic [dbc_pkg::QUO_W-1:0]  quo
);
  import dbc_pkg::*;

  logic              vld_r;
  logic [PROD_W-1:0] prod_r;
  logic [DENS_W-1:0] dvs_r;
  div_cell_t         link [0:QUO_W];

  // Product stays below span * 2^QUO_W, so its top part is below span.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r  <= start;
      prod_r <= PROD_W'(offs) * PROD_W'(nbkt);
      dvs_r  <= span;
    end
  end

  always_comb begin
    link[0].vld = vld_r;
    link[0].rem = prod_r[PROD_W-1:QUO_W];
    link[0].low = prod_r[QUO_W-1:0];
    link[0].quo = '0;
    link[0].dvs = dvs_r;
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_cell
    dbc_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .c_in  (link[k]),
      .c_out (link[k+1])
    );
  end

  assign done = link[QUO_W].vld;
  assign quo  = link[QUO_W].quo;

endmodule

[src/density_bucket_classifier.sv]
// Density bucket classifier top level: sequencer, boundary and population
// memories, output register. Depends on dbc_pkg, dbc_if, dbc_div_chain.
//
// Usage:
//   Requests arrive on in_ch (valid/ready). Opcode write stores
//   density_value as boundary entry entry_index and gives no result.
//   Opcode classify gives one result on out_ch: the bucket and its
//   population count after this request, saturating at all ones.
//   Uniform mode: the request is accepted, then passes the product
//   register and the row of eleven division cells, then the counter
//   read-modify-write; out-of-range values skip the division.
//   Quantile mode: the boundary memory is read one entry a cycle, one read
//   port, until a boundary test hits or the last bucket in use is read.
//   One request is worked on at a time; in_ch.ready is high while idle.
//   A finished result sits in the output register; the next request is
//   taken while it waits. If the receiver stalls, the next result holds in
//   the counter write step until the output register frees.
//   After reset the population memory is cleared one entry a cycle,
//   during which no request is taken; configuration writes are taken at
//   any time. Boundary entries hold nothing defined until written.
module density_bucket_classifier #(
  parameter int MAX_BUCKETS = dbc_pkg::DEF_MAX_BUCKETS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  dbc_in_if.sink                        in_ch,
  dbc_out_if.source                     out_ch,
  input  logic                          cfg_wr_en,
  input  logic [dbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dbc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dbc_pkg::*;

  localparam int BW = $clog2(MAX_BUCKETS);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_WALK  = 3'd3;
  localparam logic [2:0] ST_CRD   = 3'd4;
  localparam logic [2:0] ST_CWR   = 3'd5;

  // Configuration registers
  logic              qmode_r;
  logic [BCNT_W-1:0] bcount_r;
  logic [DENS_W-1:0] dens_low_r;
  logic [DENS_W-1:0] dens_high_r;

  // Sequencer
  logic [2:0]        state_r, state_nxt;
  logic [BW-1:0]     clr_addr_r, clr_addr_nxt;
  logic [DENS_W-1:0] val_r, val_nxt;
  logic [BCNT_W-1:0] n_r, n_nxt;
  logic [BCNT_W-1:0] bkt_r, bkt_nxt;

  // Boundary walk
  logic [BCNT_W-1:0] walk_addr_r, walk_addr_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [BCNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [DENS_W-1:0] prev_r, prev_nxt;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic [BIDX_W-1:0] out_bidx_r, out_bidx_nxt;
  logic [POP_W-1:0]  out_pop_r, out_pop_nxt;

  // Memories and their ports
  logic [DENS_W-1:0] bnd_mem_r [0:MAX_BUCKETS-1];
  logic [POP_W-1:0]  cnt_mem_r [0:MAX_BUCKETS-1];
  logic [DENS_W-1:0] bnd_rd_r;
  logic [POP_W-1:0]  cnt_rd_r;
  logic              bnd_we;
  logic              cnt_we;
  logic [BW-1:0]     cnt_wa;
  logic [POP_W-1:0]  cnt_wd;
  logic [POP_W-1:0]  cnt_inc;

  logic              in_acc;
  logic [BCNT_W-1:0] n_cfg;
  logic              div_start;
  logic              div_done;
  logic [QUO_W-1:0]  div_quo;
  logic              walk_hit;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  // Buckets in use: zero counts as one, anything above capacity saturates.
  always_comb begin
    if (bcount_r == '0) begin
      n_cfg = BCNT_W'(1);
    end else if (32'(bcount_r) > MAX_BUCKETS) begin
      n_cfg = BCNT_W'(MAX_BUCKETS);
    end else begin
      n_cfg = bcount_r;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qmode_r     <= 1'b0;
      bcount_r    <= RST_BUCKET_COUNT;
      dens_low_r  <= RST_DENSITY_LOW;
      dens_high_r <= RST_DENSITY_HIGH;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_QUANTILE_MODE: qmode_r     <= cfg_data[0];
        REG_BUCKET_COUNT:  bcount_r    <= cfg_data[BCNT_W-1:0];
        REG_DENSITY_LOW:   dens_low_r  <= cfg_data[DENS_W-1:0];
        REG_DENSITY_HIGH:  dens_high_r <= cfg_data[DENS_W-1:0];
        default: ;
      endcase
    end
  end

  dbc_div_chain u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .offs  (in_ch.density_value - dens_low_r),
    .nbkt  (n_cfg),
    .span  (dens_high_r - dens_low_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign cnt_inc = (cnt_rd_r == '1) ? cnt_rd_r : cnt_rd_r + POP_W'(1);
  assign bnd_we  = in_acc && (in_ch.opcode == OP_WRITE) &&
                   (32'(in_ch.entry_index) < MAX_BUCKETS);

  // Boundary test for the entry just read: below entry zero gives bucket
  // zero, otherwise the first entry bracketing the value from above.
  always_comb begin
    if (rd_idx_r == '0) begin
      walk_hit = val_r < bnd_rd_r;
    end else begin
      walk_hit = (prev_r <= val_r) && (val_r <= bnd_rd_r);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    val_nxt       = val_r;
    n_nxt         = n_r;
    bkt_nxt       = bkt_r;
    walk_addr_nxt = walk_addr_r;
    rd_vld_nxt    = 1'b0;
    rd_idx_nxt    = rd_idx_r;
    prev_nxt      = prev_r;
    out_valid_nxt = out_valid_r;
    out_bidx_nxt  = out_bidx_r;
    out_pop_nxt   = out_pop_r;
    div_start     = 1'b0;
    cnt_we        = 1'b0;
    cnt_wa        = BW'(bkt_r);
    cnt_wd        = cnt_inc;

    // Drop the held result once taken.
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        cnt_we       = 1'b1;
        cnt_wa       = clr_addr_r;
        cnt_wd       = '0;
        clr_addr_nxt = clr_addr_r + BW'(1);
        if (clr_addr_r == BW'(MAX_BUCKETS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc && (in_ch.opcode == OP_CLASSIFY)) begin
          val_nxt = in_ch.density_value;
          n_nxt   = n_cfg;
          if (qmode_r) begin
            walk_addr_nxt = '0;
            state_nxt     = ST_WALK;
          end else if ((dens_high_r <= dens_low_r) ||
                       (in_ch.density_value <= dens_low_r)) begin
            bkt_nxt   = '0;
            state_nxt = ST_CRD;
          end else if (in_ch.density_value >= dens_high_r) begin
            bkt_nxt   = n_cfg - BCNT_W'(1);
            state_nxt = ST_CRD;
          end else begin
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          bkt_nxt   = div_quo;
          state_nxt = ST_CRD;
        end
      end
      ST_WALK: begin
        // Issue the next read while testing the entry that came back.
        if (walk_addr_r < n_r) begin
          rd_vld_nxt    = 1'b1;
          walk_addr_nxt = walk_addr_r + BCNT_W'(1);
        end
        rd_idx_nxt = walk_addr_r;
        if (rd_vld_r) begin
          prev_nxt = bnd_rd_r;
          if (walk_hit) begin
            bkt_nxt    = rd_idx_r;
            rd_vld_nxt = 1'b0;
            state_nxt  = ST_CRD;
          end else if (rd_idx_r == n_r - BCNT_W'(1)) begin
            bkt_nxt    = rd_idx_r;
            rd_vld_nxt = 1'b0;
            state_nxt  = ST_CRD;
          end
        end
      end
      ST_CRD: begin
        state_nxt = ST_CWR;
      end
      ST_CWR: begin
        // Hold here until the output register is free.
        if (!out_valid_r || out_ch.ready) begin
          cnt_we        = 1'b1;
          out_valid_nxt = 1'b1;
          out_bidx_nxt  = bkt_r[BIDX_W-1:0];
          out_pop_nxt   = cnt_inc;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r       <= val_nxt;
    n_r         <= n_nxt;
    bkt_r       <= bkt_nxt;
    walk_addr_r <= walk_addr_nxt;
    rd_idx_r    <= rd_idx_nxt;
    prev_r      <= prev_nxt;
    out_bidx_r  <= out_bidx_nxt;
    out_pop_r   <= out_pop_nxt;
  end

  // Boundary table: written on a write request, read by the walk.
  always_ff @(posedge clk) begin
    if (bnd_we) begin
      bnd_mem_r[BW'(in_ch.entry_index)] <= in_ch.density_value;
    end
    bnd_rd_r <= bnd_mem_r[BW'(walk_addr_r)];
  end

  // Population counters: cleared after reset, then read-modify-write.
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem_r[cnt_wa] <= cnt_wd;
    end
    cnt_rd_r <= cnt_mem_r[BW'(bkt_r)];
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.bucket_id         = out_bidx_r;
  assign out_ch.bucket_population = out_pop_r;

endmodule
